[src/border_histogram_binner_assert.svh]
// Assertion macros shared by the border histogram binner modules.
`ifndef BORDER_HISTOGRAM_BINNER_ASSERT_SVH
`define BORDER_HISTOGRAM_BINNER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BHB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BHB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/bhb_pkg.sv]
// Shared types and constants of the border histogram binner.
package bhb_pkg;

    // Table sizes and the index widths that follow from them.
    localparam int MAX_BORDERS = 64;
    localparam int BIDX_W      = $clog2(MAX_BORDERS);
    localparam int CNT_W       = $clog2(MAX_BORDERS + 1);

    // Decoupling queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Register file layout.
    localparam int REG_ADDR_W = 3;
    localparam int REG_IDX_W  = 1;
    localparam logic [REG_IDX_W-1:0] REG_BORDER_COUNT = '0;

    // Running sum limits.
    localparam logic signed [63:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SUM_MIN = 64'sh8000_0000_0000_0000;

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_READ  = 2'd2,
        ACT_WRITE = 2'd3
    } t_action;

    // One classified word as it travels through the queue.
    typedef struct packed {
        t_action            action;
        logic signed [31:0] value;
        logic [5:0]         slot;
        logic               slot_ok;
    } t_item;

    // One result word.
    typedef struct packed {
        logic [31:0]        bin_count;
        logic               counted;
        logic [5:0]         landed_bin;
        logic signed [63:0] sum_of_samples;
        logic [31:0]        samples_seen;
    } t_result;

endpackage

[src/bhb_front.sv]
// Front part: accepts input words, classifies them and hands them to the queue.
module bhb_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_action,
    input  logic signed [31:0]  i_value,
    input  logic [5:0]          i_slot,
    input  logic                i_q_full,
    output logic                o_push,
    output bhb_pkg::t_item      o_item
);

    logic           r_valid;
    bhb_pkg::t_item r_item;
    bhb_pkg::t_item w_item;
    logic           w_accept;

    // Decode the action and check the slot against the table depth.
    always_comb begin
        w_item.action  = bhb_pkg::t_action'(i_action);
        w_item.value   = i_value;
        w_item.slot    = i_slot;
        w_item.slot_ok = int'(i_slot) < bhb_pkg::MAX_BORDERS;
    end

    // The staged word moves on whenever the queue has room.
    assign o_push   = r_valid && !i_q_full;
    assign o_ready  = !r_valid || o_push;
    assign w_accept = i_valid && o_ready;
    assign o_item   = r_item;

    // Input stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
        if (w_accept) begin
            r_item <= w_item;
        end
    end

endmodule

[src/bhb_queue.sv]
// Short queue of classified words between the front and back parts.
`include "border_histogram_binner_assert.svh"

module bhb_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bhb_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output bhb_pkg::t_item o_item
);

    bhb_pkg::t_item                r_mem [bhb_pkg::QUEUE_DEPTH];
    logic [bhb_pkg::QPTR_W-1:0]    r_wr;
    logic [bhb_pkg::QPTR_W-1:0]    r_rd;
    logic [bhb_pkg::QCNT_W-1:0]    r_count;

    assign o_full  = r_count == bhb_pkg::QCNT_W'(bhb_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == bhb_pkg::QPTR_W'(bhb_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == bhb_pkg::QPTR_W'(bhb_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    `BHB_ASSERT_SAME(a_no_push_full, i_clk, i_rst_n, i_push, !o_full, "push into a full queue")
    `BHB_ASSERT_SAME(a_no_pop_empty, i_clk, i_rst_n, i_pop, r_count != '0, "pop from an empty queue")
    `BHB_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + 1'b1, "fill level did not grow on push")

endmodule

[src/bhb_back.sv]
// Back part: border search, bin count update, totals and the result register.
`include "border_histogram_binner_assert.svh"

module bhb_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  bhb_pkg::t_item     i_q_item,
    output logic               o_q_pop,
    input  logic [6:0]         i_border_count,
    output logic               o_valid,
    input  logic               i_ready,
    output bhb_pkg::t_result   o_res
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_CNT_UPD,
        ST_RD_CNT,
        ST_DONE
    } t_state;

    // Border table and bin count memories with registered read data.
    logic signed [31:0]          r_border_mem [bhb_pkg::MAX_BORDERS];
    logic [31:0]                 r_count_mem  [bhb_pkg::MAX_BORDERS];
    logic signed [31:0]          r_bdata;
    logic [31:0]                 r_cdata;

    t_state                      r_state, n_state;
    bhb_pkg::t_item              r_item, n_item;
    logic [bhb_pkg::CNT_W-1:0]   r_lo, n_lo;
    logic [bhb_pkg::CNT_W-1:0]   r_hi, n_hi;
    logic [bhb_pkg::BIDX_W-1:0]  r_mid, n_mid;
    logic [bhb_pkg::BIDX_W-1:0]  r_bin, n_bin;
    logic                        r_hit, n_hit;
    logic [31:0]                 r_res_bin, n_res_bin;
    logic signed [63:0]          r_sum, n_sum;
    logic [31:0]                 r_samples, n_samples;
    logic [bhb_pkg::MAX_BORDERS-1:0] r_cvalid, n_cvalid;
    logic                        r_out_valid, n_out_valid;
    bhb_pkg::t_result            r_out, n_out;

    // Memory port controls.
    logic                        w_b_we;
    logic [bhb_pkg::BIDX_W-1:0]  w_b_addr;
    logic [bhb_pkg::BIDX_W-1:0]  w_b_raddr;
    logic                        w_c_we;
    logic [31:0]                 w_c_wdata;
    logic [bhb_pkg::BIDX_W-1:0]  w_c_raddr;

    // Search step and saturating add.
    logic [bhb_pkg::CNT_W-1:0]   w_n;
    logic                        w_le;
    logic                        w_eq;
    logic [bhb_pkg::CNT_W-1:0]   w_lo_s;
    logic [bhb_pkg::CNT_W-1:0]   w_hi_s;
    logic [bhb_pkg::CNT_W:0]     w_mid_sum;
    logic signed [63:0]          w_v64;
    logic signed [63:0]          w_sum_raw;
    logic                        w_ovf;
    logic signed [63:0]          w_sum_sat;

    assign w_n       = bhb_pkg::CNT_W'(i_border_count);
    assign w_le      = r_bdata <= r_item.value;
    assign w_eq      = r_bdata == r_item.value;
    assign w_lo_s    = w_le ? bhb_pkg::CNT_W'(r_mid) + 1'b1 : r_lo;
    assign w_hi_s    = w_le ? r_hi : bhb_pkg::CNT_W'(r_mid);
    assign w_mid_sum = {1'b0, w_lo_s} + {1'b0, w_hi_s};

    assign w_v64     = {{32{i_q_item.value[31]}}, i_q_item.value};
    assign w_sum_raw = r_sum + w_v64;
    assign w_ovf     = (r_sum[63] == w_v64[63]) && (w_sum_raw[63] != r_sum[63]);
    assign w_sum_sat = w_ovf ? (w_v64[63] ? bhb_pkg::SUM_MIN : bhb_pkg::SUM_MAX) : w_sum_raw;

    // Sequencer: one memory read per search step, then a count read-modify-write on a hit.
    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_bin       = r_bin;
        n_hit       = r_hit;
        n_res_bin   = r_res_bin;
        n_sum       = r_sum;
        n_samples   = r_samples;
        n_cvalid    = r_cvalid;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_q_pop     = 1'b0;
        w_b_we      = 1'b0;
        w_b_addr    = bhb_pkg::BIDX_W'(i_q_item.slot);
        w_b_raddr   = r_mid;
        w_c_we      = 1'b0;
        w_c_wdata   = r_cvalid[r_bin] ? r_cdata + 32'd1 : 32'd1;
        w_c_raddr   = r_bin;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop   = 1'b1;
                    n_item    = i_q_item;
                    n_hit     = 1'b0;
                    n_res_bin = '0;
                    case (i_q_item.action)
                        bhb_pkg::ACT_ADD: begin
                            n_sum     = w_sum_sat;
                            n_samples = r_samples + 32'd1;
                            if (w_n == '0) begin
                                n_state = ST_DONE;
                            end else begin
                                n_lo      = '0;
                                n_hi      = w_n;
                                n_mid     = bhb_pkg::BIDX_W'(w_n >> 1);
                                w_b_raddr = bhb_pkg::BIDX_W'(w_n >> 1);
                                n_state   = ST_SEARCH;
                            end
                        end
                        bhb_pkg::ACT_CLEAR: begin
                            n_cvalid  = '0;
                            n_sum     = '0;
                            n_samples = '0;
                            n_state   = ST_DONE;
                        end
                        bhb_pkg::ACT_READ: begin
                            w_c_raddr = bhb_pkg::BIDX_W'(i_q_item.slot);
                            n_state   = ST_RD_CNT;
                        end
                        default: begin
                            w_b_we  = i_q_item.slot_ok;
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                n_lo = w_lo_s;
                n_hi = w_hi_s;
                if (w_lo_s < w_hi_s) begin
                    n_mid     = bhb_pkg::BIDX_W'(w_mid_sum >> 1);
                    w_b_raddr = bhb_pkg::BIDX_W'(w_mid_sum >> 1);
                end else begin
                    n_state = ST_DONE;
                    if (w_lo_s == '0) begin
                        n_hit = 1'b0;
                    end else if (w_lo_s < w_n) begin
                        n_hit = 1'b1;
                        n_bin = bhb_pkg::BIDX_W'(w_lo_s - 1'b1);
                    end else if (w_eq) begin
                        // Value on the last border lands in the bin below it.
                        n_hit = 1'b1;
                        n_bin = (w_n == bhb_pkg::CNT_W'(1)) ? '0
                                                            : bhb_pkg::BIDX_W'(w_n - 2'd2);
                    end
                    if (n_hit) begin
                        w_c_raddr = n_bin;
                        n_state   = ST_CNT_UPD;
                    end
                end
            end
            ST_CNT_UPD: begin
                w_c_we          = 1'b1;
                n_cvalid[r_bin] = 1'b1;
                n_state         = ST_DONE;
            end
            ST_RD_CNT: begin
                n_res_bin = (r_item.slot_ok && r_cvalid[bhb_pkg::BIDX_W'(r_item.slot)])
                            ? r_cdata : '0;
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out.bin_count      = r_res_bin;
                    n_out.counted        = r_hit;
                    n_out.landed_bin     = r_hit ? 6'(r_bin) : '0;
                    n_out.sum_of_samples = r_sum;
                    n_out.samples_seen   = r_samples;
                    n_out_valid          = 1'b1;
                    n_state              = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_hit       <= 1'b0;
            r_sum       <= '0;
            r_samples   <= '0;
            r_cvalid    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hit       <= n_hit;
            r_sum       <= n_sum;
            r_samples   <= n_samples;
            r_cvalid    <= n_cvalid;
            r_out_valid <= n_out_valid;
        end
        r_item    <= n_item;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_mid     <= n_mid;
        r_bin     <= n_bin;
        r_res_bin <= n_res_bin;
        r_out     <= n_out;
    end

    // Border table memory.
    always_ff @(posedge i_clk) begin
        if (w_b_we) begin
            r_border_mem[w_b_addr] <= i_q_item.value;
        end
        r_bdata <= r_border_mem[w_b_raddr];
    end

    // Bin count memory; entries without a valid bit read as zero.
    always_ff @(posedge i_clk) begin
        if (w_c_we) begin
            r_count_mem[r_bin] <= w_c_wdata;
        end
        r_cdata <= r_count_mem[w_c_raddr];
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    `BHB_ASSERT_SAME(a_search_window, i_clk, i_rst_n, r_state == ST_SEARCH, r_lo < r_hi, "search window empty while searching")
    `BHB_ASSERT_SAME(a_landed_in_range, i_clk, i_rst_n, r_out_valid && r_out.counted, bhb_pkg::CNT_W'(r_out.landed_bin) < w_n, "landed bin beyond the border count")
    `BHB_ASSERT_NEXT(a_clear_takes, i_clk, i_rst_n, r_state == ST_IDLE && i_q_valid && i_q_item.action == bhb_pkg::ACT_CLEAR, r_cvalid == '0 && r_sum == '0 && r_samples == '0, "clear left counts or totals behind")

endmodule

[src/border_histogram_binner.sv]
// Border histogram binner: takes one word per action (add, clear, read bin, write
// border) and returns exactly one result word for each. An add runs a binary search
// over the border table, one border memory read per step, and then updates the bin
// count on a hit; clear, write border and read bin need no search. A four-word queue
// behind a one-word input stage lets new words enter while the back part works or a
// result waits to be taken.
// Register border_count (byte address 0) saturates at 64; borders must be loaded
// sorted and unique before adds use them.
module border_histogram_binner (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input channel.
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_action,
    input  logic signed [31:0]   i_value,
    input  logic [5:0]           i_slot,
    // Result channel.
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [31:0]          o_bin_count,
    output logic                 o_counted,
    output logic [5:0]           o_landed_bin,
    output logic signed [63:0]   o_sum_of_samples,
    output logic [31:0]          o_samples_seen,
    // Configuration port.
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [bhb_pkg::REG_ADDR_W-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [6:0]                   r_border_count;
    logic [bhb_pkg::REG_IDX_W-1:0] w_reg_idx;
    logic                         w_cfg_wr;
    bhb_pkg::t_item               w_f_item;
    bhb_pkg::t_item               w_q_item;
    logic                         w_push;
    logic                         w_full;
    logic                         w_q_valid;
    logic                         w_pop;
    bhb_pkg::t_result             w_res;

    // Configuration register.
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[bhb_pkg::REG_ADDR_W-1:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready
                       && (w_reg_idx == bhb_pkg::REG_BORDER_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_border_count <= '0;
        end else if (w_cfg_wr) begin
            r_border_count <= (int'(pwdata[6:0]) > bhb_pkg::MAX_BORDERS)
                              ? 7'(bhb_pkg::MAX_BORDERS) : pwdata[6:0];
        end
    end

    assign prdata = (w_reg_idx == bhb_pkg::REG_BORDER_COUNT) ? {25'd0, r_border_count} : '0;

    bhb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_action (i_action),
        .i_value  (i_value),
        .i_slot   (i_slot),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_item   (w_f_item)
    );

    bhb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_f_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    bhb_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_q_valid),
        .i_q_item       (w_q_item),
        .o_q_pop        (w_pop),
        .i_border_count (r_border_count),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_res          (w_res)
    );

    // Result fields.
    assign o_bin_count      = w_res.bin_count;
    assign o_counted        = w_res.counted;
    assign o_landed_bin     = w_res.landed_bin;
    assign o_sum_of_samples = w_res.sum_of_samples;
    assign o_samples_seen   = w_res.samples_seen;

endmodule

[dv/tb_border_histogram_binner.sv]
// Self-checking testbench for the border histogram binner: random words, bin prediction, checks.
`timescale 1ns / 100ps

module tb_border_histogram_binner;

    localparam int CYCLE_LIMIT       = 500000;
    localparam int DRAIN_CYCLES      = 24;
    localparam int BORDER_COUNT_ADDR = 4 * bhb_pkg::REG_BORDER_COUNT;

    // One input word waiting to be offered.
    typedef struct {
        bhb_pkg::t_action   act;
        logic signed [31:0] value;
        logic [5:0]         slot;
    } t_stim;

    // Block ports, the inputs at known values from time zero.
    logic               i_clk            = 1'b0;
    logic               i_rst_n          = 1'b0;
    logic               i_valid          = 1'b0;
    logic               o_ready;
    logic [1:0]         i_action         = bhb_pkg::ACT_ADD;
    logic signed [31:0] i_value          = '0;
    logic [5:0]         i_slot           = '0;
    logic               o_valid;
    logic               i_ready          = 1'b0;
    logic [31:0]        o_bin_count;
    logic               o_counted;
    logic [5:0]         o_landed_bin;
    logic signed [63:0] o_sum_of_samples;
    logic [31:0]        o_samples_seen;
    logic               psel             = 1'b0;
    logic               penable          = 1'b0;
    logic               pwrite           = 1'b0;
    logic [bhb_pkg::REG_ADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata           = '0;
    logic [31:0]        prdata;
    logic               pready;

    // Predicted histogram state, starting from the reset values.
    logic signed [31:0] border_mem [bhb_pkg::MAX_BORDERS] = '{default: '0};
    logic [31:0]        bin_tally [bhb_pkg::MAX_BORDERS]  = '{default: '0};
    logic signed [63:0] sum_acc    = '0;
    logic [31:0]        sample_cnt = '0;
    int unsigned        border_n   = 0;

    // Stimulus side: planned border table and the words not yet offered.
    logic signed [31:0] plan_mem [bhb_pkg::MAX_BORDERS];
    int unsigned        plan_n = 0;
    t_stim              stim_q [$];
    bhb_pkg::t_result   awaited_q [$];

    int  words_queued = 0;
    int  words_taken  = 0;
    int  mismatches   = 0;
    int  holds_asked  = 0;
    int  holds_done   = 0;
    int  cycle_count  = 0;
    int  send_gap     = 0;
    int  recv_gap     = 0;
    int  hold_left    = 0;
    bit  calm         = 1'b0;
    bit  in_taken     = 1'b0;

    int  adds_taken = 0, reads_taken = 0, clears_taken = 0, writes_taken = 0;
    int  landed_seen = 0, settings_made = 0;

    border_histogram_binner u_dut (.*);

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Applies one word to the predicted state and returns the result word it yields.
    function automatic bhb_pkg::t_result predict_histogram(input bhb_pkg::t_action act,
                                                           input logic signed [31:0] v,
                                                           input logic [5:0] slot);
        bhb_pkg::t_result   r;
        logic signed [64:0] wide;
        int unsigned        lo, hi, mid, bin;
        bit                 hit;
        r   = '0;
        hit = 1'b0;
        bin = 0;
        case (act)
            bhb_pkg::ACT_ADD: begin
                wide = sum_acc + v;
                if (wide > bhb_pkg::SUM_MAX) begin
                    sum_acc = bhb_pkg::SUM_MAX;
                end else if (wide < bhb_pkg::SUM_MIN) begin
                    sum_acc = bhb_pkg::SUM_MIN;
                end else begin
                    sum_acc = wide[63:0];
                end
                sample_cnt = sample_cnt + 1'b1;
                // A single border only takes an exact match; otherwise binary search.
                if (border_n == 1) begin
                    hit = (border_mem[0] == v);
                end else if (border_n > 1) begin
                    lo = 0;
                    hi = border_n;
                    while (lo < hi) begin
                        mid = (lo + hi) / 2;
                        if (border_mem[mid] <= v) lo = mid + 1;
                        else hi = mid;
                    end
                    if (lo != 0 && lo < border_n) begin
                        hit = 1'b1;
                        bin = lo - 1;
                    end else if (lo == border_n && v == border_mem[border_n-1]) begin
                        // The last border itself counts in the bin just below it.
                        hit = 1'b1;
                        bin = border_n - 2;
                    end
                end
                if (hit) begin
                    bin_tally[bin] = bin_tally[bin] + 1'b1;
                    r.counted      = 1'b1;
                    r.landed_bin   = bin[5:0];
                end
            end
            bhb_pkg::ACT_CLEAR: begin
                foreach (bin_tally[k]) bin_tally[k] = '0;
                sum_acc    = '0;
                sample_cnt = '0;
            end
            bhb_pkg::ACT_READ: begin
                r.bin_count = bin_tally[slot];
            end
            default: begin
                border_mem[slot] = v;
            end
        endcase
        r.sum_of_samples = sum_acc;
        r.samples_seen   = sample_cnt;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Input side: predict each accepted word; result side: compare with the oldest prediction.
    always @(posedge i_clk) begin
        bhb_pkg::t_result want;
        in_taken <= i_rst_n && i_valid && o_ready;
        if (i_rst_n && psel && penable && pwrite && pready && paddr == BORDER_COUNT_ADDR) begin
            border_n = (pwdata[6:0] > bhb_pkg::MAX_BORDERS) ? bhb_pkg::MAX_BORDERS
                                                            : pwdata[6:0];
        end
        if (i_rst_n && i_valid && o_ready) begin
            awaited_q.push_back(predict_histogram(bhb_pkg::t_action'(i_action),
                                                  i_value, i_slot));
            words_taken++;
            case (bhb_pkg::t_action'(i_action))
                bhb_pkg::ACT_ADD:   adds_taken++;
                bhb_pkg::ACT_CLEAR: clears_taken++;
                bhb_pkg::ACT_READ:  reads_taken++;
                default:            writes_taken++;
            endcase
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (awaited_q.size() == 0) begin
                $error("result word with no word waiting for it");
                mismatches++;
            end else begin
                want = awaited_q.pop_front();
                check_field("bin_count", want.bin_count, o_bin_count);
                check_field("counted", want.counted, o_counted);
                check_field("landed_bin", want.landed_bin, o_landed_bin);
                check_field("sum_of_samples", want.sum_of_samples, o_sum_of_samples);
                check_field("samples_seen", want.samples_seen, o_samples_seen);
                if (o_counted === 1'b1) landed_seen++;
            end
        end
    end

    // Sender: offers queued words, with short idle bursts after some of them.
    always @(negedge i_clk) begin
        t_stim w;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap <= 0;
        end else if (!i_valid || in_taken) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_valid  <= 1'b0;
            end else if (stim_q.size() != 0) begin
                w = stim_q.pop_front();
                i_valid  <= 1'b1;
                i_action <= w.act;
                i_value  <= w.value;
                i_slot   <= w.slot;
                if (!calm && $urandom_range(0, 6) == 0) send_gap <= $urandom_range(1, 5);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: short stall bursts, plus long hold-offs on request.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else if (holds_done != holds_asked) begin
            holds_done <= holds_done + 1;
            hold_left  <= $urandom_range(60, 120);
            i_ready    <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            i_ready  <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            recv_gap <= $urandom_range(0, 4);
            i_ready  <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, awaited_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic queue_word(input bhb_pkg::t_action act, input logic signed [31:0] v,
                              input logic [5:0] slot);
        t_stim w;
        w.act   = act;
        w.value = v;
        w.slot  = slot;
        stim_q.push_back(w);
        words_queued++;
    endtask

    // Waits until every queued word was accepted and every result has come back.
    task automatic wait_idle();
        while (words_taken != words_queued || awaited_q.size() != 0) @(posedge i_clk);
    endtask

    // Register write through the configuration port, only while the block is idle.
    task automatic write_border_count(input logic [31:0] data);
        wait_idle();
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= BORDER_COUNT_ADDR;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        plan_n = (data[6:0] > bhb_pkg::MAX_BORDERS) ? bhb_pkg::MAX_BORDERS : data[6:0];
        settings_made++;
    endtask

    // Loads n ascending, unique borders into slots 0..n-1 with a random spread.
    task automatic load_sorted(input int n);
        longint off [bhb_pkg::MAX_BORDERS];
        longint step_max, base, room, sum;
        int     k;
        case ($urandom_range(0, 2))
            0:       step_max = 4;
            1:       step_max = 65536;
            default: step_max = 33554432;
        endcase
        off[0] = 0;
        for (k = 1; k < n; k++) off[k] = off[k-1] + $urandom_range(1, step_max);
        room = 64'sd4294967295 - off[n-1];
        // Sometimes pin the table to the bottom or the top of the value range.
        case ($urandom_range(0, 3))
            0:       base = -64'sd2147483648;
            1:       base = 64'sd2147483647 - off[n-1];
            default: base = -64'sd2147483648 + longint'($urandom()) % (room + 1);
        endcase
        for (k = 0; k < n; k++) begin
            sum = base + off[k];
            plan_mem[k] = sum[31:0];
            queue_word(bhb_pkg::ACT_WRITE, plan_mem[k], k[5:0]);
        end
    endtask

    // Sample values biased toward borders, bin interiors and range extremes.
    function automatic logic signed [31:0] pick_sample();
        int top, k;
        top = (plan_n == 0) ? bhb_pkg::MAX_BORDERS - 1 : plan_n - 1;
        k   = $urandom_range(0, top);
        case ($urandom_range(0, 6))
            0:       return $urandom();
            1, 2:    return plan_mem[k];
            3:       return plan_mem[k] + $urandom_range(0, 2) - 1;
            4:       return plan_mem[top];
            5:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return plan_mem[k] + $urandom_range(0, 3);
        endcase
    endfunction

    // Random mix of words: mostly adds, with reads, clears and some border rewrites.
    task automatic queue_random(input int n);
        int                 r;
        logic [5:0]         slot;
        logic signed [31:0] v;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                queue_word(bhb_pkg::ACT_ADD, pick_sample(), 6'($urandom()));
            end else if (r < 86) begin
                queue_word(bhb_pkg::ACT_READ, $urandom(), 6'($urandom()));
            end else if (r < 89) begin
                queue_word(bhb_pkg::ACT_CLEAR, $urandom(), 6'($urandom()));
            end else begin
                // Rewrites may break the ordering, which the search must still follow.
                slot = 6'($urandom());
                v    = $urandom_range(0, 1) ? $urandom() : pick_sample();
                plan_mem[slot] = v;
                queue_word(bhb_pkg::ACT_WRITE, v, slot);
            end
        end
    endtask

    initial begin : stimulus
        int          ph;
        logic [31:0] cfg;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // No borders: adds only move the totals.
        write_border_count(32'd0);
        queue_word(bhb_pkg::ACT_ADD, 32'sh7FFF_FFFF, 6'd0);
        queue_word(bhb_pkg::ACT_ADD, 32'sh8000_0000, 6'd63);
        queue_word(bhb_pkg::ACT_ADD, 32'sd0, 6'd0);
        queue_word(bhb_pkg::ACT_ADD, -32'sd1, 6'd21);
        queue_word(bhb_pkg::ACT_READ, 32'sd0, 6'd0);
        queue_word(bhb_pkg::ACT_READ, 32'sd0, 6'd63);
        queue_word(bhb_pkg::ACT_CLEAR, 32'sd0, 6'd0);
        queue_word(bhb_pkg::ACT_ADD, 32'sd1, 6'd0);

        // Fill the whole table once so that no search ever meets an unwritten entry.
        load_sorted(bhb_pkg::MAX_BORDERS);

        // One border: only an exact match counts.
        write_border_count(32'd1);
        queue_word(bhb_pkg::ACT_ADD, plan_mem[0], 6'd0);
        queue_word(bhb_pkg::ACT_ADD, plan_mem[0] - 1, 6'd0);
        queue_word(bhb_pkg::ACT_ADD, plan_mem[0] + 1, 6'd0);

        // Two borders: the single bin, its closed top, and both outsides.
        write_border_count(32'd2);
        queue_word(bhb_pkg::ACT_ADD, plan_mem[0], 6'd0);
        queue_word(bhb_pkg::ACT_ADD, plan_mem[1], 6'd0);
        queue_word(bhb_pkg::ACT_ADD, plan_mem[1] + 1, 6'd0);
        queue_word(bhb_pkg::ACT_ADD, plan_mem[0] - 1, 6'd0);

        // Oversized count saturates to a full table.
        write_border_count(32'hFFFF_FFFF);
        queue_word(bhb_pkg::ACT_ADD, plan_mem[bhb_pkg::MAX_BORDERS-1], 6'd0);
        queue_word(bhb_pkg::ACT_ADD, 32'sh8000_0000, 6'd0);
        queue_word(bhb_pkg::ACT_ADD, 32'sh7FFF_FFFF, 6'd0);
        queue_word(bhb_pkg::ACT_READ, 32'sd0, 6'd62);
        queue_word(bhb_pkg::ACT_READ, 32'sd0, 6'd63);
        queue_word(bhb_pkg::ACT_CLEAR, 32'sd0, 6'd0);
        queue_word(bhb_pkg::ACT_READ, 32'sd0, 6'd62);

        // Random phases, each with its own border count and, mostly, a fresh table.
        for (ph = 0; ph < 15; ph++) begin
            cfg = $urandom();
            if ($urandom_range(0, 1)) cfg[31:7] = '0;
            case ($urandom_range(0, 7))
                0:       cfg[6:0] = 7'd64;
                1:       cfg[6:0] = 7'($urandom_range(65, 127));
                2:       cfg[6:0] = 7'($urandom_range(1, 3));
                3:       cfg[6:0] = 7'd0;
                default: cfg[6:0] = 7'($urandom_range(2, 64));
            endcase
            write_border_count(cfg);
            if (ph >= 13) calm = 1'b1;
            if (plan_n > 0 && $urandom_range(0, 3) != 0) load_sorted(plan_n);
            // Long result stall while words keep coming, so the block backs up.
            if (ph == 2) holds_asked++;
            queue_random(35);
            // Sender pause until every result is back.
            if (ph == 5) wait_idle();
            queue_random(35);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d words: %0d adds (%0d landed in a bin), %0d bin reads,",
                 words_taken, adds_taken, landed_seen, reads_taken);
        $display("%0d clears and %0d border writes over %0d border_count settings.",
                 clears_taken, writes_taken, settings_made);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+src
src/bhb_pkg.sv
src/bhb_front.sv
src/bhb_queue.sv
src/bhb_back.sv
src/border_histogram_binner.sv
dv/tb_border_histogram_binner.sv
